FILE: hw/rtl/sfr_pkg.sv
package sfr_pkg;

  localparam logic [7:0] CMD_LONG_MIN = 8'h80;

  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_ERROR   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_START_BYTE    = 3'd0,
    REG_END_BYTE      = 3'd1,
    REG_SHORT_LENGTH  = 3'd2,
    REG_LONG_LENGTH   = 3'd3,
    REG_TIMEOUT_TICKS = 3'd4
  } reg_idx_t;

  localparam logic [7:0]  RST_START_BYTE    = 8'd170;
  localparam logic [7:0]  RST_END_BYTE      = 8'd85;
  localparam logic [6:0]  RST_SHORT_LENGTH  = 7'd8;
  localparam logic [6:0]  RST_LONG_LENGTH   = 7'd32;
  localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd10;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [6:0]  short_length;
    logic [6:0]  long_length;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // Item after classification by the front end
  typedef struct packed {
    mode_t      mode;
    logic [7:0] rx_byte;
    logic       is_start;
    logic       is_end;
    logic       is_long;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic       byte_stored;
    logic [5:0] byte_index;
    logic [7:0] byte_value;
    logic       frame_done;
    logic       frame_good;
    logic       timed_out;
    logic       frame_pending;
  } result_t;

endpackage

FILE: hw/rtl/sfr_in_if.sv
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

FILE: hw/rtl/sfr_out_if.sv
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic       byte_stored;
  logic [5:0] byte_index;
  logic [7:0] byte_value;
  logic       frame_done;
  logic       frame_good;
  logic       timed_out;
  logic       frame_pending;

  modport source (output valid, output byte_stored, output byte_index, output byte_value,
                  output frame_done, output frame_good, output timed_out,
                  output frame_pending, input ready);
  modport sink (input valid, input byte_stored, input byte_index, input byte_value,
                input frame_done, input frame_good, input timed_out,
                input frame_pending, output ready);
endinterface

FILE: hw/rtl/sfr_front.sv
module sfr_front (
  sfr_in_if.sink        item_in,
  input  sfr_pkg::cfg_t cfg,
  input  logic          q_full,
  output sfr_pkg::push_t push
);

  assign item_in.ready = !q_full;

  always_comb begin
    push.valid         = item_in.valid && !q_full;
    push.item.mode     = sfr_pkg::mode_t'(item_in.mode);
    push.item.rx_byte  = item_in.rx_byte;
    push.item.is_start = (item_in.rx_byte == cfg.start_byte);
    push.item.is_end   = (item_in.rx_byte == cfg.end_byte);
    push.item.is_long  = (item_in.rx_byte >= sfr_pkg::CMD_LONG_MIN);
  end

endmodule

FILE: hw/rtl/sfr_queue.sv
module sfr_queue (
  input  logic           clk,
  input  logic           rst,
  input  sfr_pkg::push_t push,
  output logic           full,
  output sfr_pkg::head_t head,
  input  logic           pop
);

  sfr_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push.valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/sfr_back.sv
module sfr_back #(
  parameter int MAX_FRAME = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  sfr_pkg::cfg_t  cfg,
  input  sfr_pkg::head_t head,
  output logic           pop,
  sfr_out_if.source      result_out
);

  localparam int PW = $clog2(MAX_FRAME);
  localparam int CW = ((PW > 7) ? PW : 7) + 1;

  logic          receiving, receiving_next;
  logic          frame_ready, frame_ready_next;
  logic [PW-1:0] position, position_next;
  logic          long_frame, long_frame_next;
  logic [15:0]   idle_ticks, idle_ticks_next;

  logic             out_valid;
  sfr_pkg::result_t out_res;
  sfr_pkg::result_t res;

  logic [6:0]    len_sel;
  logic [CW-1:0] len_eff;
  logic [CW-1:0] pos_plus1;
  logic [15:0]   ticks_inc;
  logic [PW+5:0] idx_wide;

  assign pop = head.valid && (!out_valid || result_out.ready);

  always_comb begin
    len_sel = long_frame ? cfg.long_length : cfg.short_length;
    if (CW'(len_sel) > CW'(MAX_FRAME)) len_eff = CW'(MAX_FRAME);
    else len_eff = CW'(len_sel);
    pos_plus1 = CW'(position) + CW'(1);
    ticks_inc = idle_ticks + 16'd1;
    idx_wide  = {6'd0, position};
  end

  always_comb begin
    receiving_next   = receiving;
    frame_ready_next = frame_ready;
    position_next    = position;
    long_frame_next  = long_frame;
    idle_ticks_next  = idle_ticks;
    res              = '0;

    case (head.item.mode)
      sfr_pkg::MODE_BYTE: begin
        idle_ticks_next = 16'd0;
        if (!frame_ready) begin
          if (!receiving) begin
            if (head.item.is_start) begin
              res.byte_stored = 1'b1;
              res.byte_value  = head.item.rx_byte;
              position_next   = PW'(1);
              receiving_next  = 1'b1;
            end
          end else begin
            res.byte_stored = 1'b1;
            res.byte_index  = idx_wide[5:0];
            res.byte_value  = head.item.rx_byte;
            if (position <= PW'(1)) begin
              // command byte picks the frame length
              long_frame_next = head.item.is_long;
              position_next   = PW'(2);
            end else if (pos_plus1 >= len_eff) begin
              res.frame_done   = 1'b1;
              res.frame_good   = head.item.is_end;
              frame_ready_next = head.item.is_end;
              receiving_next   = 1'b0;
              position_next    = '0;
            end else begin
              position_next = position + PW'(1);
            end
          end
        end
      end
      sfr_pkg::MODE_TICK: begin
        if (receiving) begin
          idle_ticks_next = ticks_inc;
          if (ticks_inc >= cfg.timeout_ticks) begin
            receiving_next  = 1'b0;
            position_next   = '0;
            idle_ticks_next = 16'd0;
            res.timed_out   = 1'b1;
          end
        end
      end
      sfr_pkg::MODE_RELEASE: begin
        frame_ready_next = 1'b0;
      end
      sfr_pkg::MODE_ERROR: begin
        res.timed_out   = receiving;
        receiving_next  = 1'b0;
        position_next   = '0;
        idle_ticks_next = 16'd0;
      end
      default: begin
      end
    endcase

    res.frame_pending = frame_ready_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving   <= 1'b0;
      frame_ready <= 1'b0;
      position    <= '0;
      long_frame  <= 1'b0;
      idle_ticks  <= 16'd0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        receiving   <= receiving_next;
        frame_ready <= frame_ready_next;
        position    <= position_next;
        long_frame  <= long_frame_next;
        idle_ticks  <= idle_ticks_next;
        out_valid   <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (pop) out_res <= res;
  end

  assign result_out.valid         = out_valid;
  assign result_out.byte_stored   = out_res.byte_stored;
  assign result_out.byte_index    = out_res.byte_index;
  assign result_out.byte_value    = out_res.byte_value;
  assign result_out.frame_done    = out_res.frame_done;
  assign result_out.frame_good    = out_res.frame_good;
  assign result_out.timed_out     = out_res.timed_out;
  assign result_out.frame_pending = out_res.frame_pending;

endmodule

FILE: hw/rtl/serial_frame_receiver.sv
// An accepted beat is queued; on pop its result is written to the output register.
// Throughput: one beat per cycle while results are taken; the back end updates frame
// state, and a two-entry queue plus an output register decouple the two handshakes.
// Reset: rst is synchronous, active high; it empties the queue and output register,
// clears the frame state and loads the registers with their reset values.
module serial_frame_receiver #(
  parameter int MAX_FRAME = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sfr_in_if.sink      item_in,
  sfr_out_if.source   result_out
);

  sfr_pkg::cfg_t   cfg;
  sfr_pkg::push_t  push;
  sfr_pkg::head_t  head;
  sfr_pkg::reg_idx_t reg_idx;
  logic            q_full;
  logic            pop;
  logic            wr_en;

  assign pready  = 1'b1;
  assign reg_idx = sfr_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte    <= sfr_pkg::RST_START_BYTE;
      cfg.end_byte      <= sfr_pkg::RST_END_BYTE;
      cfg.short_length  <= sfr_pkg::RST_SHORT_LENGTH;
      cfg.long_length   <= sfr_pkg::RST_LONG_LENGTH;
      cfg.timeout_ticks <= sfr_pkg::RST_TIMEOUT_TICKS;
    end else if (wr_en) begin
      case (reg_idx)
        sfr_pkg::REG_START_BYTE:    cfg.start_byte    <= pwdata[7:0];
        sfr_pkg::REG_END_BYTE:      cfg.end_byte      <= pwdata[7:0];
        sfr_pkg::REG_SHORT_LENGTH:  cfg.short_length  <= pwdata[6:0];
        sfr_pkg::REG_LONG_LENGTH:   cfg.long_length   <= pwdata[6:0];
        sfr_pkg::REG_TIMEOUT_TICKS: cfg.timeout_ticks <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sfr_pkg::REG_START_BYTE:    prdata = {24'd0, cfg.start_byte};
      sfr_pkg::REG_END_BYTE:      prdata = {24'd0, cfg.end_byte};
      sfr_pkg::REG_SHORT_LENGTH:  prdata = {25'd0, cfg.short_length};
      sfr_pkg::REG_LONG_LENGTH:   prdata = {25'd0, cfg.long_length};
      sfr_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, cfg.timeout_ticks};
      default:                    prdata = 32'd0;
    endcase
  end

  sfr_front u_front (
    .item_in (item_in),
    .cfg     (cfg),
    .q_full  (q_full),
    .push    (push)
  );

  sfr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  sfr_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule

FILE: hw/rtl/sfr_checker.sv
module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic       byte_stored,
  input logic [5:0] byte_index,
  input logic [7:0] byte_value,
  input logic       frame_done,
  input logic       frame_good,
  input logic       timed_out,
  input logic       frame_pending
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable({byte_stored, byte_index, byte_value,
                                          frame_done, frame_good, timed_out,
                                          frame_pending}))
    else $error("result beat changed while stalled");

  a_good_needs_done: assert property (@(posedge clk) disable iff (rst)
    valid && frame_good |-> frame_done && frame_pending)
    else $error("good frame without completion or pending flag");

  a_done_needs_store: assert property (@(posedge clk) disable iff (rst)
    valid && frame_done |-> byte_stored && !timed_out)
    else $error("frame completed without a stored byte");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    valid && !byte_stored |-> byte_index == 6'd0 && byte_value == 8'd0)
    else $error("index or value set without a stored byte");

  a_timeout_no_store: assert property (@(posedge clk) disable iff (rst)
    valid && timed_out |-> !byte_stored)
    else $error("abort reported together with a stored byte");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (result_out.valid),
  .ready         (result_out.ready),
  .byte_stored   (result_out.byte_stored),
  .byte_index    (result_out.byte_index),
  .byte_value    (result_out.byte_value),
  .frame_done    (result_out.frame_done),
  .frame_good    (result_out.frame_good),
  .timed_out     (result_out.timed_out),
  .frame_pending (result_out.frame_pending)
);

FILE: tb/sfr_frame_checker.sv
`timescale 1ns / 1ps
module sfr_frame_checker #(
  parameter int MAX_FRAME = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       in_mode,
  input  logic [7:0]       in_rx_byte,
  input  logic             out_valid,
  input  logic             out_ready,
  input  sfr_pkg::result_t out_result,
  output int               mismatches,
  output int               outstanding
);

  sfr_pkg::cfg_t    regs;
  logic             in_frame;
  logic             held;
  logic [5:0]       next_pos;
  logic             is_long_cmd;
  logic [15:0]      quiet_ticks;
  sfr_pkg::result_t results_due[$];

  function automatic void drop_partial();
    in_frame = 1'b0;
    next_pos = '0;
    quiet_ticks = '0;
  endfunction

  function automatic sfr_pkg::result_t frame_step(sfr_pkg::mode_t m, logic [7:0] b);
    sfr_pkg::result_t r;
    int len;
    r = '0;
    case (m)
      sfr_pkg::MODE_BYTE: begin
        quiet_ticks = '0;
        if (!held) begin
          if (!in_frame) begin
            if (b == regs.start_byte) begin
              r.byte_stored = 1'b1;
              r.byte_value = b;
              next_pos = 6'd1;
              in_frame = 1'b1;
            end
          end else begin
            r.byte_stored = 1'b1;
            r.byte_index = next_pos;
            r.byte_value = b;
            if (next_pos <= 6'd1) begin
              is_long_cmd = (b >= sfr_pkg::CMD_LONG_MIN);
              next_pos = 6'd2;
            end else begin
              len = is_long_cmd ? int'(regs.long_length) : int'(regs.short_length);
              if (len > MAX_FRAME) len = MAX_FRAME;
              if (int'(next_pos) + 1 >= len) begin
                r.frame_done = 1'b1;
                r.frame_good = (b == regs.end_byte);
                held = r.frame_good;
                in_frame = 1'b0;
                next_pos = '0;
              end else begin
                next_pos = next_pos + 6'd1;
              end
            end
          end
        end
      end
      sfr_pkg::MODE_TICK: begin
        // idle ticks only count inside a partial frame
        if (in_frame) begin
          quiet_ticks = quiet_ticks + 16'd1;
          if (quiet_ticks >= regs.timeout_ticks) begin
            drop_partial();
            r.timed_out = 1'b1;
          end
        end
      end
      sfr_pkg::MODE_RELEASE: held = 1'b0;
      sfr_pkg::MODE_ERROR: begin
        r.timed_out = in_frame;
        drop_partial();
      end
      default: ;
    endcase
    r.frame_pending = held;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : track
    sfr_pkg::result_t want;
    if (rst) begin
      regs = '{start_byte: sfr_pkg::RST_START_BYTE, end_byte: sfr_pkg::RST_END_BYTE,
               short_length: sfr_pkg::RST_SHORT_LENGTH,
               long_length: sfr_pkg::RST_LONG_LENGTH,
               timeout_ticks: sfr_pkg::RST_TIMEOUT_TICKS};
      in_frame = 1'b0;
      held = 1'b0;
      next_pos = '0;
      is_long_cmd = 1'b0;
      quiet_ticks = '0;
      results_due.delete();
      mismatches = 0;
    end else begin
      // compare before pushing so a stray beat never matches its own event
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result beat with no event waiting");
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("byte_stored", want.byte_stored, out_result.byte_stored);
          check_field("byte_index", want.byte_index, out_result.byte_index);
          check_field("byte_value", want.byte_value, out_result.byte_value);
          check_field("frame_done", want.frame_done, out_result.frame_done);
          check_field("frame_good", want.frame_good, out_result.frame_good);
          check_field("timed_out", want.timed_out, out_result.timed_out);
          check_field("frame_pending", want.frame_pending, out_result.frame_pending);
        end
      end
      if (in_valid && in_ready) begin
        results_due.push_back(frame_step(sfr_pkg::mode_t'(in_mode), in_rx_byte));
      end
      if (psel && penable && pwrite && pready) begin
        case (sfr_pkg::reg_idx_t'(paddr[4:2]))
          sfr_pkg::REG_START_BYTE:    regs.start_byte = pwdata[7:0];
          sfr_pkg::REG_END_BYTE:      regs.end_byte = pwdata[7:0];
          sfr_pkg::REG_SHORT_LENGTH:  regs.short_length = pwdata[6:0];
          sfr_pkg::REG_LONG_LENGTH:   regs.long_length = pwdata[6:0];
          sfr_pkg::REG_TIMEOUT_TICKS: regs.timeout_ticks = pwdata[15:0];
          default: ;
        endcase
      end
    end
    outstanding = results_due.size();
  end

endmodule

FILE: tb/tb_serial_frame_receiver.sv
`timescale 1ns / 1ps
module tb_serial_frame_receiver;

  localparam int FRAME_CAP = 64;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 8;
  localparam int PHASE_EVENTS = 152;
  localparam int HOLD_CYCLES = 150;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          outstanding;

  sfr_pkg::cfg_t cur_cfg;
  int            sent;
  bit            tx_quiet;

  sfr_in_if  item_in ();
  sfr_out_if result_out ();

  serial_frame_receiver #(.MAX_FRAME(FRAME_CAP)) uut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .item_in(item_in),
    .result_out(result_out)
  );

  sfr_frame_checker #(.MAX_FRAME(FRAME_CAP)) frame_check (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid(item_in.valid),
    .in_ready(item_in.ready),
    .in_mode(item_in.mode),
    .in_rx_byte(item_in.rx_byte),
    .out_valid(result_out.valid),
    .out_ready(result_out.ready),
    .out_result({result_out.byte_stored, result_out.byte_index, result_out.byte_value,
                 result_out.frame_done, result_out.frame_good, result_out.timed_out,
                 result_out.frame_pending}),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("serial_frame_receiver regression: fail");
    $finish;
  end

  // Result sink: random stalls per beat, quiet stretches, and two long hold-offs
  initial begin : result_sink
    int rx_count;
    int stall;
    bit rx_quiet;
    rx_count = 0;
    rx_quiet = 1'b0;
    result_out.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_count % 64 == 0) rx_quiet = ($urandom_range(3, 0) == 0);
      if (rx_count == 300 || rx_count == 800) stall = HOLD_CYCLES;
      else stall = rx_quiet ? 0 : $urandom_range(11, 0);
      if (stall > 0) begin
        result_out.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_out.ready = 1'b1;
      @(posedge clk);
      while (!result_out.valid) @(posedge clk);
      rx_count++;
      @(negedge clk);
    end
  end

  task automatic send_event(sfr_pkg::mode_t m, logic [7:0] b);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(11, 0);
    if (gap > 0) begin
      item_in.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_in.mode = m;
    item_in.rx_byte = b;
    item_in.valid = 1'b1;
    @(posedge clk);
    while (!item_in.ready) @(posedge clk);
    @(negedge clk);
    sent++;
    if (sent % 40 == 0) tx_quiet = ($urandom_range(3, 0) == 0);
  endtask

  task automatic drain();
    item_in.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(sfr_pkg::reg_idx_t idx, logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic load_settings(sfr_pkg::cfg_t c);
    drain();
    write_reg(sfr_pkg::REG_START_BYTE, 32'(c.start_byte));
    write_reg(sfr_pkg::REG_END_BYTE, 32'(c.end_byte));
    write_reg(sfr_pkg::REG_SHORT_LENGTH, 32'(c.short_length));
    write_reg(sfr_pkg::REG_LONG_LENGTH, 32'(c.long_length));
    write_reg(sfr_pkg::REG_TIMEOUT_TICKS, 32'(c.timeout_ticks));
    cur_cfg = c;
  endtask

  function automatic sfr_pkg::cfg_t phase_settings(int ph);
    sfr_pkg::cfg_t c;
    c.start_byte = 8'($urandom);
    c.end_byte = 8'($urandom);
    c.short_length = 7'($urandom_range(10, 3));
    c.long_length = 7'($urandom_range(14, 3));
    c.timeout_ticks = 16'($urandom_range(6, 1));
    case (ph)
      0: c = '{8'h00, 8'hFF, 7'd3, 7'd64, 16'd1};
      1: c = '{8'hFF, 8'h00, 7'd127, 7'd2, 16'hFFFF};
      2: begin
        c.short_length = 7'd1;
        c.long_length = 7'd0;
        c.timeout_ticks = 16'd0;
      end
      default: ;
    endcase
    return c;
  endfunction

  // Mostly whole frames with random content; some cut short, some plain noise
  task automatic run_traffic(int count);
    int stop_at;
    int pick;
    int len;
    int n;
    logic [7:0] cmd;
    stop_at = sent + count;
    while (sent < stop_at) begin
      pick = $urandom_range(99, 0);
      cmd = 8'($urandom);
      len = (cmd >= sfr_pkg::CMD_LONG_MIN) ? int'(cur_cfg.long_length)
                                           : int'(cur_cfg.short_length);
      if (len > FRAME_CAP) len = FRAME_CAP;
      if (len < 3) len = 3;
      if (pick < 80) begin
        send_event(sfr_pkg::MODE_BYTE, cur_cfg.start_byte);
        send_event(sfr_pkg::MODE_BYTE, cmd);
        n = (pick < 65) ? len : $urandom_range(len - 1, 2);
        for (int i = 2; i < n; i++) begin
          if ($urandom_range(15, 0) == 0) send_event(sfr_pkg::MODE_TICK, 8'($urandom));
          if (i == len - 1 && $urandom_range(4, 0) != 0) begin
            send_event(sfr_pkg::MODE_BYTE, cur_cfg.end_byte);
          end else begin
            send_event(sfr_pkg::MODE_BYTE, 8'($urandom));
          end
        end
        if (pick >= 65) begin
          if ($urandom_range(1, 0) == 1) begin
            send_event(sfr_pkg::MODE_ERROR, 8'($urandom));
          end else begin
            n = (cur_cfg.timeout_ticks > 20) ? 20 : int'(cur_cfg.timeout_ticks);
            n += $urandom_range(1, 0);
            repeat (n) send_event(sfr_pkg::MODE_TICK, 8'($urandom));
          end
        end else if ($urandom_range(6, 0) != 0) begin
          send_event(sfr_pkg::MODE_RELEASE, 8'($urandom));
        end
      end else begin
        send_event(sfr_pkg::mode_t'($urandom_range(3, 0)), 8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    sfr_pkg::cfg_t c;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_in.valid = 1'b0;
    item_in.mode = sfr_pkg::MODE_BYTE;
    item_in.rx_byte = 8'h00;
    sent = 0;
    tx_quiet = 1'b0;
    cur_cfg = '{sfr_pkg::RST_START_BYTE, sfr_pkg::RST_END_BYTE, sfr_pkg::RST_SHORT_LENGTH,
                sfr_pkg::RST_LONG_LENGTH, sfr_pkg::RST_TIMEOUT_TICKS};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: idle error, idle tick, release with nothing held,
    // dropped byte, start, long command, line error inside a frame
    send_event(sfr_pkg::MODE_ERROR, 8'hFF);
    send_event(sfr_pkg::MODE_TICK, 8'h00);
    send_event(sfr_pkg::MODE_RELEASE, 8'h5A);
    send_event(sfr_pkg::MODE_BYTE, 8'h00);
    send_event(sfr_pkg::MODE_BYTE, sfr_pkg::RST_START_BYTE);
    send_event(sfr_pkg::MODE_BYTE, 8'hFF);
    send_event(sfr_pkg::MODE_ERROR, 8'h00);

    // short length below three, zero timeout
    load_settings('{8'h00, 8'hFF, 7'd0, 7'd3, 16'd0});
    send_event(sfr_pkg::MODE_BYTE, 8'h00);
    send_event(sfr_pkg::MODE_BYTE, 8'h7F);
    send_event(sfr_pkg::MODE_BYTE, 8'hFF);
    send_event(sfr_pkg::MODE_BYTE, 8'h00);
    send_event(sfr_pkg::MODE_RELEASE, 8'h00);
    send_event(sfr_pkg::MODE_BYTE, 8'h00);
    send_event(sfr_pkg::MODE_BYTE, 8'h80);
    send_event(sfr_pkg::MODE_BYTE, 8'h12);
    send_event(sfr_pkg::MODE_BYTE, 8'h00);
    send_event(sfr_pkg::MODE_TICK, 8'h00);

    // a byte clears the idle count
    c = cur_cfg;
    c.timeout_ticks = 16'd2;
    load_settings(c);
    send_event(sfr_pkg::MODE_BYTE, 8'h00);
    send_event(sfr_pkg::MODE_TICK, 8'h00);
    send_event(sfr_pkg::MODE_BYTE, 8'h80);
    send_event(sfr_pkg::MODE_TICK, 8'h00);
    send_event(sfr_pkg::MODE_TICK, 8'h00);

    for (int ph = 0; ph < PHASES; ph++) begin
      load_settings(phase_settings(ph));
      run_traffic(PHASE_EVENTS);
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("serial_frame_receiver regression: pass");
    else $display("serial_frame_receiver regression: fail");
    $finish;
  end

endmodule

FILE: serial_frame_receiver.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_in_if.sv
hw/rtl/sfr_out_if.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_queue.sv
hw/rtl/sfr_back.sv
hw/rtl/serial_frame_receiver.sv
hw/rtl/sfr_checker.sv
tb/sfr_frame_checker.sv
tb/tb_serial_frame_receiver.sv
